FILE: rtl/weighted_consensus_column_caller_macros.svh
// Assertion macros shared by the consensus column caller modules.
`ifndef WEIGHTED_CONSENSUS_COLUMN_CALLER_MACROS_SVH
`define WEIGHTED_CONSENSUS_COLUMN_CALLER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define WCCC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define WCCC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/wccc_pkg.sv
// Types, constants and helper functions of the consensus column caller.
`timescale 1ns / 1ps
`default_nettype none
package wccc_pkg;

	localparam int TOT_W = 28;
	localparam int GAP_W = 11;
	localparam int NCLS  = 5;
	localparam int INC_W = 18;

	typedef logic [TOT_W-1:0] total_t;
	typedef logic [GAP_W-1:0] gap_t;
	typedef logic [INC_W-1:0] inc_t;
	typedef logic [2:0]       cls_t;
	typedef logic [7:0]       char_t;

	localparam cls_t CLS_GAP = 3'd0;
	localparam cls_t CLS_A   = 3'd1;
	localparam cls_t CLS_C   = 3'd2;
	localparam cls_t CLS_G   = 3'd3;
	localparam cls_t CLS_U   = 3'd4;

	localparam total_t TOTAL_MAX = '1;
	localparam gap_t   GAP_MAX   = '1;

	localparam char_t CH_DASH = 8'h2D;
	localparam char_t CH_DOT  = 8'h2E;
	localparam char_t CH_UA   = 8'h41;
	localparam char_t CH_UC   = 8'h43;
	localparam char_t CH_UG   = 8'h47;
	localparam char_t CH_UU   = 8'h55;
	localparam char_t CH_UZ   = 8'h5A;
	localparam char_t CH_LA   = 8'h61;
	localparam char_t CH_LC   = 8'h63;
	localparam char_t CH_LG   = 8'h67;
	localparam char_t CH_LN   = 8'h6E;
	localparam char_t CH_LR   = 8'h72;
	localparam char_t CH_LU   = 8'h75;
	localparam char_t CH_LY   = 8'h79;
	localparam char_t CASE_BIT = 8'h20;

	typedef struct packed {
		char_t       residue;
		logic [15:0] weight;
		logic        last_in_column;
	} in_item_t;

	typedef struct packed {
		char_t consensus_char;
		gap_t  gap_tally;
	} out_item_t;

	typedef struct packed {
		total_t [NCLS-1:0] class_tot;
		total_t            total;
		gap_t              gaps;
	} col_sum_t;

	function automatic total_t sat_add(input total_t acc, input inc_t inc);
		logic [TOT_W:0] s;
		s = {1'b0, acc} + {{(TOT_W + 1 - INC_W){1'b0}}, inc};
		return s[TOT_W] ? TOTAL_MAX : s[TOT_W-1:0];
	endfunction

	function automatic char_t class_char(input cls_t cls, input logic upper);
		char_t c;
		unique case (cls)
			CLS_A:   c = upper ? CH_UA : CH_LA;
			CLS_C:   c = upper ? CH_UC : CH_LC;
			CLS_G:   c = upper ? CH_UG : CH_LG;
			CLS_U:   c = upper ? CH_UU : CH_LU;
			default: c = CH_DASH;
		endcase
		return c;
	endfunction

endpackage
`default_nettype wire

FILE: rtl/wccc_stream_if.sv
// Valid/ready stream interface that carries one item per handshake.
`timescale 1ns / 1ps
`default_nettype none
interface wccc_stream_if #(
	parameter type item_t = logic
);
	logic  valid;
	logic  ready;
	item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: rtl/wccc_accum.sv
// Input register, column accumulators and end-of-column snapshot register.
`timescale 1ns / 1ps
`default_nettype none
`include "weighted_consensus_column_caller_macros.svh"
module wccc_accum
	import wccc_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	wccc_stream_if.sink   col_in,
	input  wire logic     snap_ready,
	output logic          snap_valid,
	output col_sum_t      snap
);

	in_item_t item_s1;
	logic     valid_s1;
	logic     s1_adv;
	logic     s2_free;

	total_t   cls_q [NCLS];
	total_t   tot_q;
	gap_t     gap_q;

	char_t    ch;
	inc_t     inc1, inc2, inc4;
	inc_t     inc [NCLS];
	logic     is_gap;
	col_sum_t sum_next;

	assign s2_free      = !snap_valid || snap_ready;
	assign s1_adv       = valid_s1 && (!item_s1.last_in_column || s2_free);
	assign col_in.ready = !valid_s1 || s1_adv;

	always_comb begin
		ch = item_s1.residue;
		if (ch >= CH_UA && ch <= CH_UZ) begin
			ch = ch | CASE_BIT;
		end
		inc1 = {2'b00, item_s1.weight};
		inc2 = {1'b0, item_s1.weight, 1'b0};
		inc4 = {item_s1.weight, 2'b00};
		for (int i = 0; i < NCLS; i++) begin
			inc[i] = '0;
		end
		is_gap = 1'b0;
		unique case (ch)
			CH_LA: inc[CLS_A] = inc4;
			CH_LC: inc[CLS_C] = inc4;
			CH_LG: inc[CLS_G] = inc4;
			CH_LU: inc[CLS_U] = inc4;
			CH_LR: begin
				inc[CLS_A] = inc2;
				inc[CLS_G] = inc2;
			end
			CH_LY: begin
				inc[CLS_C] = inc2;
				inc[CLS_U] = inc2;
			end
			CH_LN: begin
				inc[CLS_A] = inc1;
				inc[CLS_C] = inc1;
				inc[CLS_G] = inc1;
				inc[CLS_U] = inc1;
			end
			CH_DASH, CH_DOT: begin
				inc[CLS_GAP] = inc4;
				is_gap       = 1'b1;
			end
			default: ;
		endcase
		for (int i = 0; i < NCLS; i++) begin
			sum_next.class_tot[i] = sat_add(cls_q[i], inc[i]);
		end
		sum_next.total = sat_add(tot_q, inc4);
		sum_next.gaps  = (is_gap && gap_q != GAP_MAX) ? gap_q + 1'b1 : gap_q;
	end

	always_ff @(posedge clk) begin
		if (col_in.valid && col_in.ready) begin
			item_s1 <= col_in.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (col_in.valid && col_in.ready) begin
			valid_s1 <= 1'b1;
		end else if (s1_adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NCLS; i++) begin
				cls_q[i] <= '0;
			end
			tot_q <= '0;
			gap_q <= '0;
		end else if (s1_adv) begin
			if (item_s1.last_in_column) begin
				for (int i = 0; i < NCLS; i++) begin
					cls_q[i] <= '0;
				end
				tot_q <= '0;
				gap_q <= '0;
			end else begin
				for (int i = 0; i < NCLS; i++) begin
					cls_q[i] <= sum_next.class_tot[i];
				end
				tot_q <= sum_next.total;
				gap_q <= sum_next.gaps;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv && item_s1.last_in_column) begin
			snap <= sum_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			snap_valid <= 1'b0;
		end else if (s1_adv && item_s1.last_in_column) begin
			snap_valid <= 1'b1;
		end else if (snap_ready) begin
			snap_valid <= 1'b0;
		end
	end

	`WCCC_ASSERT_NEXT(a_clear_after_last, clk, arst_n,
		s1_adv && item_s1.last_in_column,
		tot_q == '0 && gap_q == '0, "accumulators not cleared after the last item")
	`WCCC_ASSERT_NOW(a_class_below_total, clk, arst_n, 1'b1,
		cls_q[CLS_GAP] <= tot_q && cls_q[CLS_A] <= tot_q && cls_q[CLS_C] <= tot_q &&
		cls_q[CLS_G] <= tot_q && cls_q[CLS_U] <= tot_q,
		"a class total exceeds the column total")
	`WCCC_ASSERT_NOW(a_last_needs_room, clk, arst_n,
		s1_adv && item_s1.last_in_column, s2_free,
		"snapshot overwritten before it was taken")

endmodule
`default_nettype wire

FILE: rtl/wccc_decide.sv
// Consensus decision on a column snapshot and the result register.
`timescale 1ns / 1ps
`default_nettype none
`include "weighted_consensus_column_caller_macros.svh"
module wccc_decide
	import wccc_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      snap_valid,
	input  wire col_sum_t  snap,
	output logic           snap_ready,
	wccc_stream_if.source  col_out
);

	logic      out_valid_q;
	out_item_t out_data_q;

	cls_t      idx_a, idx_b, idx_c, top_cls;
	total_t    val_a, val_b, val_c, best_val;
	logic [NCLS-1:0] eq;
	logic      unique_best;
	logic      majority;
	logic      acgu_equal;
	char_t     cons;

	assign snap_ready    = !out_valid_q || col_out.ready;
	assign col_out.valid = out_valid_q;
	assign col_out.data  = out_data_q;

	always_comb begin
		// The left entry wins ties, so the earliest class with the maximum is kept.
		if (snap.class_tot[CLS_A] > snap.class_tot[CLS_GAP]) begin
			idx_a = CLS_A;
			val_a = snap.class_tot[CLS_A];
		end else begin
			idx_a = CLS_GAP;
			val_a = snap.class_tot[CLS_GAP];
		end
		if (snap.class_tot[CLS_G] > snap.class_tot[CLS_C]) begin
			idx_b = CLS_G;
			val_b = snap.class_tot[CLS_G];
		end else begin
			idx_b = CLS_C;
			val_b = snap.class_tot[CLS_C];
		end
		if (val_b > val_a) begin
			idx_c = idx_b;
			val_c = val_b;
		end else begin
			idx_c = idx_a;
			val_c = val_a;
		end
		if (snap.class_tot[CLS_U] > val_c) begin
			top_cls = CLS_U;
			best_val = snap.class_tot[CLS_U];
		end else begin
			top_cls = idx_c;
			best_val = val_c;
		end

		for (int i = 0; i < NCLS; i++) begin
			eq[i] = (snap.class_tot[i] == best_val);
		end
		unique_best = ((eq & (eq - 1'b1)) == '0);
		majority    = ({best_val, 1'b0} >= {1'b0, snap.total});
		acgu_equal  = (snap.class_tot[CLS_A] == snap.class_tot[CLS_G]) &&
			(snap.class_tot[CLS_U] == snap.class_tot[CLS_C]) &&
			(snap.class_tot[CLS_A] == snap.class_tot[CLS_U]);

		priority if (snap.total == '0) begin
			cons = CH_LN;
		end else if (majority) begin
			cons = class_char(top_cls, 1'b1);
		end else if (unique_best) begin
			cons = class_char(top_cls, 1'b0);
		end else if (acgu_equal) begin
			cons = CH_LN;
		end else if ((top_cls == CLS_A || top_cls == CLS_G) &&
			snap.class_tot[CLS_A] == snap.class_tot[CLS_G]) begin
			cons = CH_LR;
		end else if ((top_cls == CLS_U || top_cls == CLS_C) &&
			snap.class_tot[CLS_U] == snap.class_tot[CLS_C]) begin
			cons = CH_LY;
		end else begin
			cons = CH_LN;
		end
	end

	always_ff @(posedge clk) begin
		if (snap_valid && snap_ready) begin
			out_data_q.consensus_char <= cons;
			out_data_q.gap_tally      <= snap.gaps;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (snap_valid && snap_ready) begin
			out_valid_q <= 1'b1;
		end else if (col_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	`WCCC_ASSERT_NEXT(a_zero_total_gives_n, clk, arst_n,
		snap_valid && snap_ready && snap.total == '0,
		out_data_q.consensus_char == CH_LN, "empty column did not give n")
	`WCCC_ASSERT_NEXT(a_snapshot_loads_result, clk, arst_n,
		snap_valid && snap_ready, out_valid_q && out_data_q.gap_tally == $past(snap.gaps),
		"snapshot taken but no matching result")
	`WCCC_ASSERT_NOW(a_best_is_max, clk, arst_n, snap_valid,
		best_val >= snap.class_tot[CLS_GAP] && best_val >= snap.class_tot[CLS_A] &&
		best_val >= snap.class_tot[CLS_C] && best_val >= snap.class_tot[CLS_G] &&
		best_val >= snap.class_tot[CLS_U], "selected class is not the maximum")

endmodule
`default_nettype wire

FILE: rtl/weighted_consensus_column_caller.sv
// Top level of the weighted consensus caller for one alignment column.
// Throughput: one residue item per cycle, back to back, unless col_out stalls.
// An accepted last item leads via the snapshot register to the result register.
// Stages: input register, accumulators with snapshot register, result register.
// Reset: arst_n clears all valid flags, class totals, total weight and gap count.
`timescale 1ns / 1ps
`default_nettype none
module weighted_consensus_column_caller
	import wccc_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	wccc_stream_if.sink   col_in,
	wccc_stream_if.source col_out
);

	logic     snap_valid;
	logic     snap_ready;
	col_sum_t snap;

	wccc_accum u_accum (
		.clk        (clk),
		.arst_n     (arst_n),
		.col_in     (col_in),
		.snap_ready (snap_ready),
		.snap_valid (snap_valid),
		.snap       (snap)
	);

	wccc_decide u_decide (
		.clk        (clk),
		.arst_n     (arst_n),
		.snap_valid (snap_valid),
		.snap       (snap),
		.snap_ready (snap_ready),
		.col_out    (col_out)
	);

endmodule
`default_nettype wire
